/* src/assert_macros.svh */
// Assertion macros shared by the control responder RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define UCRR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define UCRR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ucrr_pkg.sv */
// Package for the control endpoint responder: request codes, response kinds,
// state and job types, and the configuration descriptor table. No dependencies.
`timescale 1ns / 1ps

package ucrr_pkg;

  // Fixed packet size of the control pipe and defaults for the bulk endpoints.
  localparam int unsigned EP0_PACKET_BYTES      = 8;
  localparam int unsigned BULK_OUT_PACKET_BYTES = 64;
  localparam int unsigned BULK_IN_PACKET_BYTES  = 64;

  // Descriptor and reply lengths in bytes.
  localparam logic [6:0] DEV_DESC_LEN    = 7'd18;
  localparam logic [6:0] CFG_DESC_LEN    = 7'h43;
  localparam logic [6:0] LINE_CODING_LEN = 7'd7;
  localparam logic [6:0] STATUS_LEN      = 7'd2;
  localparam logic [6:0] GET_CONFIG_LEN  = 7'd1;

  // Descriptor selectors in wValue.
  localparam logic [15:0] DESC_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_CONFIG = 16'h0200;

  // Request keys: bRequest in the high byte, bmRequestType in the low byte.
  localparam logic [15:0] RQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] RQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] RQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] RQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] RQ_STATUS_DEV     = 16'h0080;
  localparam logic [15:0] RQ_STATUS_IF      = 16'h0081;
  localparam logic [15:0] RQ_STATUS_EP      = 16'h0082;
  localparam logic [15:0] RQ_SETF_DEV       = 16'h0300;
  localparam logic [15:0] RQ_SETF_IF        = 16'h0301;
  localparam logic [15:0] RQ_SETF_EP        = 16'h0302;
  localparam logic [15:0] RQ_CLRF_DEV       = 16'h0100;
  localparam logic [15:0] RQ_CLRF_IF        = 16'h0101;
  localparam logic [15:0] RQ_CLRF_EP        = 16'h0102;
  localparam logic [15:0] RQ_SET_LINE       = 16'h2021;
  localparam logic [15:0] RQ_GET_LINE       = 16'h21A1;
  localparam logic [15:0] RQ_SET_CTRL       = 16'h2221;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VENDOR_ID,
    CFG_PRODUCT_ID,
    CFG_DEVICE_RELEASE,
    CFG_LINE_BAUD
  } cfg_reg_e;

  // Kinds of result items.
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ZLP,
    KIND_STALL,
    KIND_RESET
  } rsp_kind_e;

  // Where the bytes of a data reply come from.
  typedef enum logic [1:0] {
    SRC_DEV,
    SRC_CFG,
    SRC_LINE,
    SRC_SHORT
  } src_e;

  // Device state held in the state memory.
  typedef struct packed {
    logic [6:0] addr;
    logic       addr_en;
    logic       configured;
    logic [7:0] config_value;
    logic [2:0] ep_en;
    logic [7:0] line_state;
  } dev_state_t;

  // One decoded setup item.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } req_t;

  // Reply job handed from the decoder to the packetizer.
  typedef struct packed {
    rsp_kind_e   kind;
    src_e        src;
    logic [6:0]  len;
    logic [15:0] short_word;
    dev_state_t  post;
  } job_t;

  // Registered result item.
  typedef struct packed {
    rsp_kind_e   kind;
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    dev_state_t  post;
  } rsp_t;

  // Configuration descriptor, eight bytes per word, first byte in the low bits.
  // The bulk packet size bytes are left zero here and patched in by the packetizer.
  function automatic logic [63:0] cfg_rom_word(input logic [3:0] idx);
    logic [63:0] w;
    unique case (idx)
      4'd0:    w = 64'hC000_0102_0043_0209;
      4'd1:    w = 64'h0202_0100_0004_0900;
      4'd2:    w = 64'h0401_1000_2405_0000;
      4'd3:    w = 64'h0100_0624_0500_0224;
      4'd4:    w = 64'h8305_0701_0001_2405;
      4'd5:    w = 64'h0001_0409_FF00_0803;
      4'd6:    w = 64'h0105_0700_0000_0A02;
      4'd7:    w = 64'h0282_0507_0000_0002;
      default: w = 64'h0;
    endcase
    return w;
  endfunction

endpackage

/* src/ucrr_if.sv */
// Valid/ready channel interfaces of the control responder: setup items in,
// result items out. No dependencies.
`timescale 1ns / 1ps

interface ucrr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] setup_length;

  modport source (
    output valid, req_type, request_type, request_code,
           setup_value, setup_index, setup_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, request_type, request_code,
           setup_value, setup_index, setup_length,
    output ready
  );
endinterface

interface ucrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response_kind;
  logic [63:0] packet_bytes;
  logic [3:0]  byte_count;
  logic        last_packet;
  logic [6:0]  address_out;
  logic        address_valid;
  logic        configured_out;
  logic [2:0]  endpoint_enable_mask;
  logic [7:0]  line_state_out;

  modport source (
    output valid, response_kind, packet_bytes, byte_count, last_packet,
           address_out, address_valid, configured_out,
           endpoint_enable_mask, line_state_out,
    input  ready
  );
  modport sink (
    input  valid, response_kind, packet_bytes, byte_count, last_packet,
           address_out, address_valid, configured_out,
           endpoint_enable_mask, line_state_out,
    output ready
  );
endinterface

/* src/usb_control_request_responder_core.sv */
//  Channel   Direction  Handshake        Item
//  setup_i   in         valid / ready    setup packet or end of bus reset
//  resp_o    out        valid / ready    data packet, status, stall or reset ack
//  cfg_*     in         write enable     vendor, product, release, baud registers
// An accepted item reads the device state memory on its accepting edge and then
// waits in the decode stage while the previous reply is still sent. Replies
// leave at one packet per cycle while the output is not stalled, one packet per
// 8 data bytes and at least one. The first result item passes the decode, job
// and output registers. Reset clears all control state at once; a stalled
// output holds its item while the next one is decoded.
// Depends on ucrr_pkg, ucrr_if.sv, ucrr_packetizer and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usb_control_request_responder_core
  import ucrr_pkg::*;
#(
  parameter int unsigned BULK_OUT_BYTES = BULK_OUT_PACKET_BYTES,
  parameter int unsigned BULK_IN_BYTES  = BULK_IN_PACKET_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  ucrr_req_if.sink    setup_i,
  ucrr_rsp_if.source  resp_o
);

  logic [15:0] vendor_id_q;
  logic [15:0] product_id_q;
  logic [15:0] device_release_q;
  logic [31:0] line_baud_q;

  dev_state_t  state_mem_q [1];
  logic        state_vld_q;
  dev_state_t  rd_q;

  logic        b_valid_q;
  req_t        b_req_q;
  req_t        req_in;

  logic        in_acc;
  logic        b_adv;
  logic        st_we;
  dev_state_t  st_wdata;
  job_t        job;
  logic        job_ready;

  logic [15:0] key;
  logic [15:0] wval;
  logic [3:0]  ep;
  logic [15:0] wlen;
  logic [2:0]  ep_onehot;
  logic        ep_enabled;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_id_q      <= 16'd1003;
      product_id_q     <= 16'd24869;
      device_release_q <= 16'd272;
      line_baud_q      <= 32'd115200;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_VENDOR_ID:      vendor_id_q      <= cfg_wdata_i[15:0];
        CFG_PRODUCT_ID:     product_id_q     <= cfg_wdata_i[15:0];
        CFG_DEVICE_RELEASE: device_release_q <= cfg_wdata_i[15:0];
        CFG_LINE_BAUD:      line_baud_q      <= cfg_wdata_i;
        default:            line_baud_q      <= line_baud_q;
      endcase
    end
  end

  // Input handshake: the decode stage takes an item when empty or moving on.
  assign b_adv         = b_valid_q && job_ready;
  assign setup_i.ready = !b_valid_q || job_ready;
  assign in_acc        = setup_i.valid && setup_i.ready;

  assign req_in = '{req_type:     setup_i.req_type,
                    request_type: setup_i.request_type,
                    request_code: setup_i.request_code,
                    setup_value:  setup_i.setup_value,
                    setup_index:  setup_i.setup_index,
                    setup_length: setup_i.setup_length};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_acc) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_req_q <= req_in;
    end
  end

  // State memory: one entry, written back by the decode stage. The read for a
  // new item forwards a write-back that lands on the same edge.
  assign st_we = b_adv;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem_q[0] <= st_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_vld_q <= 1'b0;
    end else if (st_we) begin
      state_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (st_we) begin
        rd_q <= st_wdata;
      end else if (state_vld_q) begin
        rd_q <= state_mem_q[0];
      end else begin
        rd_q <= '0;
      end
    end
  end

  // Request fields used by the decoder.
  assign key  = {b_req_q.request_code, b_req_q.request_type};
  assign wval = b_req_q.setup_value;
  assign ep   = b_req_q.setup_index[3:0];
  assign wlen = b_req_q.setup_length;

  // Endpoint number as a bit of the enable mask; zero outside one to three.
  always_comb begin
    unique case (ep)
      4'd1:    ep_onehot = 3'b001;
      4'd2:    ep_onehot = 3'b010;
      4'd3:    ep_onehot = 3'b100;
      default: ep_onehot = 3'b000;
    endcase
  end

  assign ep_enabled = (ep == 4'd0) || ((rd_q.ep_en & ep_onehot) != 3'b000);

  // Decode: new state and the reply job.
  always_comb begin
    st_wdata       = rd_q;
    job.kind       = KIND_STALL;
    job.src        = SRC_SHORT;
    job.len        = '0;
    job.short_word = '0;
    priority if (b_req_q.req_type) begin
      // End of bus reset: everything but the line state goes back to zero.
      st_wdata.addr         = '0;
      st_wdata.addr_en      = 1'b0;
      st_wdata.configured   = 1'b0;
      st_wdata.config_value = '0;
      st_wdata.ep_en        = '0;
      job.kind              = KIND_RESET;
    end else begin
      unique case (key)
        RQ_GET_DESCRIPTOR: begin
          if (wval == DESC_DEVICE) begin
            job.kind = KIND_DATA;
            job.src  = SRC_DEV;
            job.len  = (wlen < 16'(DEV_DESC_LEN)) ? wlen[6:0] : DEV_DESC_LEN;
          end else if (wval == DESC_CONFIG) begin
            job.kind = KIND_DATA;
            job.src  = SRC_CFG;
            job.len  = (wlen < 16'(CFG_DESC_LEN)) ? wlen[6:0] : CFG_DESC_LEN;
          end
        end
        RQ_SET_ADDRESS: begin
          st_wdata.addr       = wval[6:0];
          st_wdata.addr_en    = (wval != 16'h0);
          st_wdata.configured = 1'b0;
          job.kind            = KIND_ZLP;
        end
        RQ_SET_CONFIG: begin
          st_wdata.config_value = wval[7:0];
          st_wdata.configured   = (wval != 16'h0);
          st_wdata.addr_en      = (wval == 16'h0);
          st_wdata.ep_en        = (wval != 16'h0) ? 3'b111 : 3'b000;
          job.kind              = KIND_ZLP;
        end
        RQ_GET_CONFIG: begin
          job.kind       = KIND_DATA;
          job.len        = GET_CONFIG_LEN;
          job.short_word = {8'h00, rd_q.config_value};
        end
        RQ_STATUS_DEV, RQ_STATUS_IF: begin
          job.kind = KIND_DATA;
          job.len  = STATUS_LEN;
        end
        RQ_STATUS_EP: begin
          if ((rd_q.configured && ep <= 4'd3) || (rd_q.addr_en && ep == 4'd0)) begin
            job.kind       = KIND_DATA;
            job.len        = STATUS_LEN;
            job.short_word = {15'h0, !ep_enabled};
          end
        end
        RQ_SETF_IF, RQ_CLRF_IF, RQ_SET_LINE: begin
          job.kind = KIND_ZLP;
        end
        RQ_SETF_EP, RQ_CLRF_EP: begin
          // Endpoint halt: a set disables the endpoint, a clear enables it.
          if (wval == 16'h0 && ep_onehot != 3'b000) begin
            if (key == RQ_SETF_EP) begin
              st_wdata.ep_en = rd_q.ep_en & ~ep_onehot;
            end else begin
              st_wdata.ep_en = rd_q.ep_en | ep_onehot;
            end
            job.kind = KIND_ZLP;
          end
        end
        RQ_GET_LINE: begin
          job.kind = KIND_DATA;
          job.src  = SRC_LINE;
          job.len  = (wlen < 16'(LINE_CODING_LEN)) ? wlen[6:0] : LINE_CODING_LEN;
        end
        RQ_SET_CTRL: begin
          st_wdata.line_state = wval[7:0];
          job.kind            = KIND_ZLP;
        end
        default: begin
          job.kind = KIND_STALL;
        end
      endcase
    end
    job.post = st_wdata;
  end

  ucrr_packetizer #(
    .BULK_OUT_BYTES (BULK_OUT_BYTES),
    .BULK_IN_BYTES  (BULK_IN_BYTES)
  ) u_packetizer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (b_valid_q),
    .job_i            (job),
    .job_ready_o      (job_ready),
    .vendor_id_i      (vendor_id_q),
    .product_id_i     (product_id_q),
    .device_release_i (device_release_q),
    .line_baud_i      (line_baud_q),
    .resp_o           (resp_o)
  );

  // A read that meets a write-back of the same edge sees the new state.
  `UCRR_ASSERT(a_state_fwd, clk_i, rst_ni, (in_acc && st_we) |=> (rd_q == $past(st_wdata)), "state forward lost")
  // A stalled decode stage keeps its item.
  `UCRR_ASSERT(a_decode_hold, clk_i, rst_ni, (b_valid_q && !b_adv) |=> (b_valid_q && $stable(b_req_q)), "decode item lost")
  // Bus reset leaves the control line state as it was.
  `UCRR_ASSERT(a_reset_line, clk_i, rst_ni, (st_we && b_req_q.req_type) |-> (st_wdata.line_state == rd_q.line_state), "line state changed by bus reset")

endmodule

/* src/ucrr_packetizer.sv */
// Packetizer: splits one reply job into 8-byte result items and holds them in
// the output register. Depends on ucrr_pkg, ucrr_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucrr_packetizer
  import ucrr_pkg::*;
#(
  parameter int unsigned BULK_OUT_BYTES = BULK_OUT_PACKET_BYTES,
  parameter int unsigned BULK_IN_BYTES  = BULK_IN_PACKET_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_ready_o,
  input  logic [15:0]       vendor_id_i,
  input  logic [15:0]       product_id_i,
  input  logic [15:0]       device_release_i,
  input  logic [31:0]       line_baud_i,
  ucrr_rsp_if.source        resp_o
);

  localparam logic [15:0] BulkOutW = 16'(BULK_OUT_BYTES);
  localparam logic [15:0] BulkInW  = 16'(BULK_IN_BYTES);

  logic        c_valid_q;
  job_t        job_q;
  logic [3:0]  pkt_q;
  logic        out_valid_q;
  rsp_t        out_q;

  logic        emit;
  logic        pkt_last;
  logic [6:0]  rem;
  logic [3:0]  cnt;
  logic [63:0] src_word;
  logic [63:0] cfg_word;
  logic [63:0] masked;
  rsp_t        out_d;

  // Bytes left from the current packet on, and the size of this packet.
  assign rem = job_q.len - {pkt_q, 3'b000};
  assign cnt = (rem >= 7'd8) ? 4'd8 : rem[3:0];

  // Configuration descriptor word with the bulk packet sizes filled in.
  always_comb begin
    cfg_word = cfg_rom_word(pkt_q);
    if (pkt_q == 4'd7) begin
      cfg_word[15:8]  = BulkOutW[7:0];
      cfg_word[23:16] = BulkOutW[15:8];
    end else if (pkt_q == 4'd8) begin
      cfg_word[7:0]   = BulkInW[7:0];
      cfg_word[15:8]  = BulkInW[15:8];
    end
  end

  // Select the eight source bytes of the current packet.
  always_comb begin
    src_word = '0;
    unique case (job_q.src)
      SRC_DEV: begin
        if (pkt_q == 4'd0) begin
          src_word = {8'(EP0_PACKET_BYTES), 56'h00_0002_0110_0112};
        end else if (pkt_q == 4'd1) begin
          src_word = {16'h0000, device_release_i, product_id_i, vendor_id_i};
        end else if (pkt_q == 4'd2) begin
          src_word = 64'h0100;
        end
      end
      SRC_CFG:   src_word = cfg_word;
      SRC_LINE:  src_word = {8'h00, 8'h08, 16'h0000, line_baud_i};
      SRC_SHORT: src_word = {48'h0, job_q.short_word};
      default:   src_word = '0;
    endcase
  end

  // Keep only the bytes that belong to this packet.
  always_comb begin
    masked = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        masked[8*i +: 8] = src_word[8*i +: 8];
      end
    end
  end

  // Result item for the current packet; non-data replies are a single item.
  always_comb begin
    out_d.kind = job_q.kind;
    out_d.post = job_q.post;
    if (job_q.kind == KIND_DATA) begin
      out_d.bytes = masked;
      out_d.count = cnt;
      out_d.last  = (rem <= 7'd8);
    end else begin
      out_d.bytes = '0;
      out_d.count = '0;
      out_d.last  = 1'b1;
    end
  end

  assign pkt_last    = out_d.last;
  assign emit        = c_valid_q && (!out_valid_q || resp_o.ready);
  assign job_ready_o = !c_valid_q || (emit && pkt_last);

  // Control: job busy flag and output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        c_valid_q <= 1'b1;
      end else if (emit && pkt_last) begin
        c_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (resp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: job, packet index and output item.
  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
      pkt_q <= 4'd0;
    end else if (emit) begin
      pkt_q <= pkt_q + 4'd1;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  // Output channel.
  assign resp_o.valid                = out_valid_q;
  assign resp_o.response_kind        = out_q.kind;
  assign resp_o.packet_bytes         = out_q.bytes;
  assign resp_o.byte_count           = out_q.count;
  assign resp_o.last_packet          = out_q.last;
  assign resp_o.address_out          = out_q.post.addr;
  assign resp_o.address_valid        = out_q.post.addr_en;
  assign resp_o.configured_out       = out_q.post.configured;
  assign resp_o.endpoint_enable_mask = out_q.post.ep_en;
  assign resp_o.line_state_out       = out_q.post.line_state;

  // A reply never runs past nine packets.
  `UCRR_ASSERT(a_pkt_range, clk_i, rst_ni, c_valid_q |-> (pkt_q <= 4'd8), "packet index overrun")
  // Status, stall and reset replies are one empty, final item.
  `UCRR_ASSERT(a_nodata_item, clk_i, rst_ni, (emit && job_q.kind != KIND_DATA) |=> (resp_o.valid && resp_o.last_packet && resp_o.byte_count == 4'd0), "bad non-data item")
  // After the final packet the unit is free unless a new job was taken.
  `UCRR_ASSERT(a_job_done, clk_i, rst_ni, (emit && pkt_last) |=> (!c_valid_q || $past(job_valid_i)), "job not retired")

endmodule
